// ===== sv/efe_pkg.sv =====
// Shared types and constants for the escaped frame encoder with CRC-8.
// Used by efe_seq, efe_obuf, escaped_frame_encoder_crc8 and the testbench.
package efe_pkg;

    localparam logic [7:0] OPEN_MARK  = 8'h5E;
    localparam logic [7:0] CLOSE_MARK = 8'h5F;
    localparam logic [7:0] ESC_MARK   = 8'h5C;
    localparam logic [7:0] ESC_FLIP   = 8'h20;

    localparam logic [7:0] OWN_ADDR_RESET = 8'h00;
    localparam logic [7:0] CRC_POLY_RESET = 8'h83;

    // configuration register indexes
    localparam logic REG_OWN_ADDR = 1'b0;
    localparam logic REG_CRC_POLY = 1'b1;

    // frame symbol being sent, one-hot
    typedef enum logic [5:0] {
        PH_OPEN  = 6'b000001,
        PH_OWN   = 6'b000010,
        PH_DEST  = 6'b000100,
        PH_DATA  = 6'b001000,
        PH_CRC   = 6'b010000,
        PH_CLOSE = 6'b100000
    } phase_t;

    // one line byte handed from the sequencer to the output register
    typedef struct packed {
        logic       vld;
        logic [7:0] data;
        logic       run_last;
        logic       frame_end;
    } emit_t;

endpackage

// ===== sv/efe_crc_fold.sv =====
// One-byte MSB-first CRC-8 update with a run-time polynomial.
// Depends on nothing outside this file.
module efe_crc_fold (
    input  logic [7:0] crc_in,
    input  logic [7:0] data,
    input  logic [7:0] poly,
    output logic [7:0] crc_out
);

    always_comb
    begin
        logic [7:0] c;
        c = crc_in ^ data;
        for (int k = 0; k < 8; k++)
        begin
            if (c[7])
            begin
                c = {c[6:0], 1'b0} ^ poly;
            end
            else
            begin
                c = {c[6:0], 1'b0};
            end
        end
        crc_out = c;
    end

endmodule

// ===== sv/efe_seq.sv =====
// Request register and byte sequencer: walks the frame symbols of one request,
// escapes them and folds the CRC. Depends on efe_pkg and efe_crc_fold.
module efe_seq (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    input  logic [7:0]    payload_byte,
    input  logic [7:0]    dest_address,
    input  logic          last_byte,
    input  logic [7:0]    own_address,
    input  logic [7:0]    crc_polynomial,
    input  logic          slot_free,
    output efe_pkg::emit_t emit
);

    import efe_pkg::*;

    logic         item_vld_reg, item_vld_next;
    logic [7:0]   data_reg;
    logic [7:0]   dest_reg;
    logic         last_reg;
    phase_t       phase_reg, phase_next;
    logic         esc_reg, esc_next;
    logic [7:0]   crc_reg, crc_next;
    logic         inside_reg, inside_next;

    logic [7:0]   sym;
    logic         escapable;
    logic         is_special;
    logic         fire;
    logic         needs_esc;
    logic         advance;
    logic         done;
    logic         accept;
    logic [7:0]   fold_in;
    logic [7:0]   fold_out;

    assign fold_in = (phase_reg == PH_OWN) ? 8'h00 : crc_reg;

    efe_crc_fold u_fold (
        .crc_in  (fold_in),
        .data    (sym),
        .poly    (crc_polynomial),
        .crc_out (fold_out)
    );

    always_comb
    begin
        case (phase_reg)
            PH_OPEN:  sym = OPEN_MARK;
            PH_OWN:   sym = own_address;
            PH_DEST:  sym = dest_reg;
            PH_DATA:  sym = data_reg;
            PH_CRC:   sym = crc_reg;
            PH_CLOSE: sym = CLOSE_MARK;
            default:  sym = data_reg;
        endcase

        // delimiters go out raw
        escapable  = (phase_reg != PH_OPEN) && (phase_reg != PH_CLOSE);
        is_special = sym inside {ESC_MARK, OPEN_MARK, CLOSE_MARK};
        fire       = item_vld_reg && slot_free;
        needs_esc  = escapable && is_special && !esc_reg;
        advance    = fire && !needs_esc;
        done       = advance && ((phase_reg == PH_CLOSE)
                                 || ((phase_reg == PH_DATA) && !last_reg));

        emit.vld       = fire;
        emit.data      = esc_reg ? (sym ^ ESC_FLIP) : (needs_esc ? ESC_MARK : sym);
        emit.run_last  = done;
        emit.frame_end = fire && (phase_reg == PH_CLOSE);

        in_stall = item_vld_reg && !done;
        accept   = in_valid && !in_stall;

        esc_next    = fire ? needs_esc : esc_reg;
        crc_next    = crc_reg;
        inside_next = inside_reg;
        phase_next  = phase_reg;

        if (advance)
        begin
            case (phase_reg)
                PH_OPEN:
                begin
                    phase_next  = PH_OWN;
                    inside_next = 1'b1;
                end
                PH_OWN:
                begin
                    phase_next = PH_DEST;
                    crc_next   = fold_out;
                end
                PH_DEST:
                begin
                    phase_next = PH_DATA;
                    crc_next   = fold_out;
                end
                PH_DATA:
                begin
                    crc_next = fold_out;
                    if (last_reg)
                    begin
                        phase_next = PH_CRC;
                    end
                end
                PH_CRC:
                begin
                    phase_next = PH_CLOSE;
                end
                PH_CLOSE:
                begin
                    phase_next  = PH_OPEN;
                    crc_next    = 8'h00;
                    inside_next = 1'b0;
                end
                default:
                begin
                    phase_next = PH_OPEN;
                end
            endcase
        end

        // a new request opens a frame unless one is still running
        if (accept)
        begin
            phase_next = inside_next ? PH_DATA : PH_OPEN;
        end

        if (accept)
        begin
            item_vld_next = 1'b1;
        end
        else if (done)
        begin
            item_vld_next = 1'b0;
        end
        else
        begin
            item_vld_next = item_vld_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_vld_reg <= 1'b0;
            phase_reg    <= PH_OPEN;
            esc_reg      <= 1'b0;
            crc_reg      <= 8'h00;
            inside_reg   <= 1'b0;
        end
        else
        begin
            item_vld_reg <= item_vld_next;
            phase_reg    <= phase_next;
            esc_reg      <= esc_next;
            crc_reg      <= crc_next;
            inside_reg   <= inside_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            data_reg <= payload_byte;
            dest_reg <= dest_address;
            last_reg <= last_byte;
        end
    end

endmodule

// ===== sv/efe_obuf.sv =====
// Output register between the sequencer and the line side.
// Depends on efe_pkg for the emit_t type.
module efe_obuf (
    input  logic           clk,
    input  logic           rst_n,
    input  efe_pkg::emit_t emit,
    output logic           slot_free,
    output logic           out_valid,
    input  logic           out_stall,
    output logic [7:0]     out_byte,
    output logic           run_last,
    output logic           frame_end
);

    import efe_pkg::*;

    logic       vld_reg, vld_next;
    logic [7:0] byte_reg;
    logic       run_last_reg;
    logic       frame_end_reg;

    // take a new byte when empty or when the held one leaves this cycle
    assign slot_free = !vld_reg || !out_stall;
    assign vld_next  = slot_free ? emit.vld : vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (slot_free && emit.vld)
        begin
            byte_reg      <= emit.data;
            run_last_reg  <= emit.run_last;
            frame_end_reg <= emit.frame_end;
        end
    end

    assign out_valid = vld_reg;
    assign out_byte  = byte_reg;
    assign run_last  = run_last_reg;
    assign frame_end = frame_end_reg;

endmodule

// ===== sv/escaped_frame_encoder_crc8.sv =====
// Top level of the escaped frame encoder with CRC-8: configuration registers,
// sequencer and output register. Depends on efe_pkg, efe_seq and efe_obuf.
//
// Each request is one payload byte and produces one line byte per clock cycle
// into the output register while that register has room. A payload byte inside
// a frame causes 1 or 2 line bytes, and a one-byte frame with every field escaped
// causes up to 10. A new request is taken in the same cycle its predecessor emits
// its last byte, so requests follow each other without a gap. The CRC is folded
// one byte per cycle, while the output register has room, as each address or
// payload byte goes out. Configuration is written through cfg_wr_en / cfg_index /
// cfg_data into registers that the sequencer reads.
module escaped_frame_encoder_crc8 (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wr_en,
    input  logic       cfg_index,
    input  logic [7:0] cfg_data,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] payload_byte,
    input  logic [7:0] dest_address,
    input  logic       last_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic       run_last,
    output logic       frame_end
);

    import efe_pkg::*;

    logic [7:0] own_addr_reg, own_addr_next;
    logic [7:0] crc_poly_reg, crc_poly_next;
    emit_t      emit;
    logic       slot_free;

    always_comb
    begin
        own_addr_next = own_addr_reg;
        crc_poly_next = crc_poly_reg;
        if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_OWN_ADDR: own_addr_next = cfg_data;
                REG_CRC_POLY: crc_poly_next = cfg_data;
                default:      own_addr_next = own_addr_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_addr_reg <= OWN_ADDR_RESET;
            crc_poly_reg <= CRC_POLY_RESET;
        end
        else
        begin
            own_addr_reg <= own_addr_next;
            crc_poly_reg <= crc_poly_next;
        end
    end

    efe_seq u_seq (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .payload_byte   (payload_byte),
        .dest_address   (dest_address),
        .last_byte      (last_byte),
        .own_address    (own_addr_reg),
        .crc_polynomial (crc_poly_reg),
        .slot_free      (slot_free),
        .emit           (emit)
    );

    efe_obuf u_obuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .emit      (emit),
        .slot_free (slot_free),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_byte  (out_byte),
        .run_last  (run_last),
        .frame_end (frame_end)
    );

    // the closing delimiter always ends the run of its request
    a_close_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_end |-> run_last && (out_byte == CLOSE_MARK))
        else $error("frame_end without run_last or closing delimiter");

    // an escape prefix never ends a run or a frame
    a_esc_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_byte == ESC_MARK) |-> !run_last && !frame_end)
        else $error("escape prefix ends a run");

    // a byte is only emitted toward a free output slot
    a_emit_slot: assert property (@(posedge clk) disable iff (!rst_n)
        emit.vld |-> slot_free)
        else $error("sequencer emitted into a full output register");

    // a new request is taken only when the previous one is finishing
    a_accept_done: assert property (@(posedge clk) disable iff (!rst_n)
        !in_stall && u_seq.item_vld_reg |-> emit.run_last)
        else $error("request register overwritten before its run ended");

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for escaped_frame_encoder_crc8: byte-stuffed frames with CRC-8.
// Depends on efe_pkg and the RTL under sv/; a scoreboard class predicts the line bytes.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import efe_pkg::*;

    localparam int CYCLE_LIMIT = 300000;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic [7:0] data;
        logic       run_last;
        logic       frame_end;
    } line_byte_t;

    class frame_scoreboard;
        logic [7:0] own_addr;
        logic [7:0] poly;
        logic [7:0] crc;
        bit         in_frame;
        line_byte_t line_q[$];
        line_byte_t held;
        bit         have_held;
        int         failures;

        function new();
            own_addr  = OWN_ADDR_RESET;
            poly      = CRC_POLY_RESET;
            crc       = 8'h00;
            in_frame  = 1'b0;
            have_held = 1'b0;
            failures  = 0;
        endfunction

        function void write_reg(logic idx, logic [7:0] value);
            if (idx == REG_OWN_ADDR)
                own_addr = value;
            else
                poly = value;
        endfunction

        function logic [7:0] fold(logic [7:0] acc, logic [7:0] b);
            logic [7:0] c;
            c = acc ^ b;
            for (int k = 0; k < 8; k++)
                c = c[7] ? ((c << 1) ^ poly) : (c << 1);
            return c;
        endfunction

        // hold the newest byte back so run_last can be set on it
        function void emit(logic [7:0] b, logic fe);
            if (have_held)
                line_q.push_back(held);
            held      = '{data: b, run_last: 1'b0, frame_end: fe};
            have_held = 1'b1;
        endfunction

        function void emit_stuffed(logic [7:0] b);
            if (b == ESC_MARK || b == OPEN_MARK || b == CLOSE_MARK)
            begin
                emit(ESC_MARK, 1'b0);
                emit(b ^ ESC_FLIP, 1'b0);
            end
            else
                emit(b, 1'b0);
        endfunction

        function void note_request(logic [7:0] payload, logic [7:0] dest, logic last);
            if (!in_frame)
            begin
                emit(OPEN_MARK, 1'b0);
                crc = fold(8'h00, own_addr);
                emit_stuffed(own_addr);
                crc = fold(crc, dest);
                emit_stuffed(dest);
                in_frame = 1'b1;
            end
            crc = fold(crc, payload);
            emit_stuffed(payload);
            if (last)
            begin
                emit_stuffed(crc);
                emit(CLOSE_MARK, 1'b1);
                in_frame = 1'b0;
                crc      = 8'h00;
            end
            held.run_last = 1'b1;
            line_q.push_back(held);
            have_held = 1'b0;
        endfunction

        function void report(string msg);
            failures++;
            if (failures <= MAX_REPORTS)
                $display("%s", msg);
        endfunction

        function void check_result(logic [7:0] b, logic rl, logic fe);
            line_byte_t want;
            if (line_q.size() == 0)
            begin
                report($sformatf("unexpected line byte %h run_last %b frame_end %b", b, rl, fe));
                return;
            end
            want = line_q.pop_front();
            if (want.data !== b || want.run_last !== rl || want.frame_end !== fe)
                report($sformatf("mismatch: expected %h/%b/%b, got %h/%b/%b",
                                 want.data, want.run_last, want.frame_end, b, rl, fe));
        endfunction

        function int pending();
            return line_q.size();
        endfunction
    endclass

    logic       clk          = 1'b0;
    logic       rst_n        = 1'b0;
    logic       cfg_wr_en    = 1'b0;
    logic       cfg_index    = 1'b0;
    logic [7:0] cfg_data     = 8'h00;
    logic       in_valid     = 1'b0;
    logic       in_stall;
    logic [7:0] payload_byte = 8'h00;
    logic [7:0] dest_address = 8'h00;
    logic       last_byte    = 1'b0;
    logic       out_valid;
    logic       out_stall    = 1'b0;
    logic [7:0] out_byte;
    logic       run_last;
    logic       frame_end;

    int sender_idle_pct = 0;
    int recv_stall_pct  = 0;
    int cycles          = 0;

    frame_scoreboard sb = new();

    escaped_frame_encoder_crc8 u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .payload_byte (payload_byte),
        .dest_address (dest_address),
        .last_byte    (last_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_byte     (out_byte),
        .run_last     (run_last),
        .frame_end    (frame_end)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    always @(posedge clk)
        out_stall <= ($urandom_range(99) < recv_stall_pct);

    // check outputs before noting the request taken at the same edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                sb.check_result(out_byte, run_last, frame_end);
            if (in_valid && !in_stall)
                sb.note_request(payload_byte, dest_address, last_byte);
        end
    end

    // bias toward the bytes that need stuffing, their flipped forms, 00 and FF
    function automatic logic [7:0] pick_byte();
        logic [7:0] specials [8] = '{8'h5C, 8'h5E, 8'h5F, 8'h7C, 8'h7E, 8'h7F, 8'h00, 8'hFF};
        if ($urandom_range(3) == 0)
            return specials[3'($urandom_range(7))];
        return 8'($urandom_range(255));
    endfunction

    task automatic send_request(logic [7:0] p, logic [7:0] d, logic l);
        int gap;
        gap = 0;
        while (gap < 12 && $urandom_range(99) < sender_idle_pct)
            gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        payload_byte <= p;
        dest_address <= d;
        last_byte    <= l;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // hold off the sender until every predicted byte has arrived
    task automatic drain_results();
        in_valid <= 1'b0;
        // let the request taken at the last edge reach the scoreboard
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_config(logic [7:0] own, logic [7:0] poly);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_OWN_ADDR;
        cfg_data  <= own;
        @(posedge clk);
        sb.write_reg(REG_OWN_ADDR, own);
        cfg_index <= REG_CRC_POLY;
        cfg_data  <= poly;
        @(posedge clk);
        sb.write_reg(REG_CRC_POLY, poly);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_frames(int count);
        int         len;
        logic [7:0] dest;
        while (count > 0)
        begin
            len  = ($urandom_range(9) == 0) ? $urandom_range(8, 16) : $urandom_range(1, 4);
            dest = pick_byte();
            for (int i = 0; i < len; i++)
            begin
                // dest changes mid-frame must be ignored
                if (i > 0 && $urandom_range(1) == 1)
                    dest = 8'($urandom_range(255));
                send_request(pick_byte(), dest, (i == len - 1));
                count--;
            end
        end
    endtask

    initial
    begin
        logic [7:0] probe;
        static logic [7:0] run_own [4]  = '{8'h00, 8'hFF, 8'h5F, 8'h00};
        static logic [7:0] run_poly [4] = '{8'hFF, 8'h00, 8'h83, 8'h07};
        static int         idle_pct [4] = '{0, 50, 0, 15};
        static int         stall_pct [4] = '{0, 0, 50, 15};

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: single-byte frames at reset settings and the extremes
        send_request(8'h00, 8'h00, 1'b1);
        send_request(8'hFF, 8'h7E, 1'b1);
        drain_results();
        set_config(8'hFF, 8'hFF);
        send_request(8'hFF, 8'hFF, 1'b1);
        drain_results();
        set_config(8'h5E, 8'h00);
        send_request(8'h5C, 8'h5F, 1'b1);
        drain_results();

        // own address, destination and CRC all escaped: a long run for one request
        set_config(8'h5C, CRC_POLY_RESET);
        probe = 8'h00;
        for (int v = 0; v < 256; v++)
        begin
            logic [7:0] c;
            c = sb.fold(sb.fold(sb.fold(8'h00, 8'h5C), 8'h5E), 8'(v));
            if (c == ESC_MARK || c == OPEN_MARK || c == CLOSE_MARK)
                probe = 8'(v);
        end
        send_request(probe, 8'h5E, 1'b1);

        // multi-byte frame with dest ignored after the opener
        send_request(8'h5D, 8'h12, 1'b0);
        send_request(8'h5E, 8'hAA, 1'b0);
        send_request(8'h5F, 8'h55, 1'b0);
        send_request(8'h80, 8'h00, 1'b0);
        send_request(8'h7F, 8'hFF, 1'b1);

        // register writes with a frame open
        send_request(8'h01, 8'h40, 1'b0);
        drain_results();
        set_config(8'h33, 8'h07);
        send_request(8'h02, 8'h41, 1'b0);
        send_request(8'h03, 8'h42, 1'b1);
        send_request(8'h7E, 8'h7C, 1'b1);
        send_request(8'h20, 8'h01, 1'b0);
        send_request(8'h7C, 8'h02, 1'b1);

        // random phases, each with its own settings and idle pattern
        for (int ph = 0; ph < 4; ph++)
        begin
            drain_results();
            sender_idle_pct = idle_pct[ph];
            recv_stall_pct  = stall_pct[ph];
            set_config(run_own[ph], run_poly[ph]);
            send_frames(42);
            if (ph == 1)
                drain_results();
            if (ph == 2)
            begin
                // leave a frame open across a write
                send_request(pick_byte(), pick_byte(), 1'b0);
                drain_results();
                set_config(pick_byte(), 8'($urandom_range(255)));
                send_request(pick_byte(), pick_byte(), 1'b1);
            end
            if (ph == 3)
            begin
                drain_results();
                set_config(pick_byte(), 8'($urandom_range(255)));
            end
            send_frames(42);
        end

        drain_results();
        repeat (20) @(posedge clk);
        if (sb.failures == 0 && sb.pending() == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule
